// File: rtl/tsp_pkg.sv
// tsp_pkg: shared types and constants for the task scheduler picker
// no dependencies
package tsp_pkg;
   localparam int MaxTasks = 64;
   localparam int SlotW = 6;
   localparam int PrioW = 8;
   localparam int WeightW = 17;
   localparam int DeltaW = 32;
   localparam int VrtW = 64;

   localparam logic [1:0] ModeAdd = 2'd0;
   localparam logic [1:0] ModeRemove = 2'd1;
   localparam logic [1:0] ModePick = 2'd2;

   localparam logic [1:0] PolRr = 2'd0;
   localparam logic [1:0] PolPrio = 2'd1;
   localparam logic [1:0] PolCfs = 2'd2;

   localparam logic csr_policy_idx = 1'b0;
   localparam logic csr_nice_idx = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_UPD,
      ST_SCAN,
      ST_DONE
   } state_type;

   // data carried around the ring of cells
   typedef struct packed {
      logic             valid;
      logic [PrioW-1:0] prio;
      logic [WeightW-1:0] weight;
      logic [VrtW-1:0]  vrt;
   } entry_type;
endpackage

// File: rtl/tsp_cell.sv
// tsp_cell: one slot of the rotating task ring
// depends on tsp_pkg
module tsp_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                shift,
   input  logic                load,
   input  tsp_pkg::entry_type  load_data,
   input  tsp_pkg::entry_type  prev_data,
   output tsp_pkg::entry_type  data
);
   tsp_pkg::entry_type data_ff;
   logic valid_in;

   always_comb begin
      valid_in = data_ff.valid;
      if (load) begin
         valid_in = load_data.valid;
      end else if (shift) begin
         valid_in = prev_data.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff.valid <= 1'b0;
      end else begin
         data_ff.valid <= valid_in;
      end
      if (load) begin
         data_ff.prio <= load_data.prio;
         data_ff.weight <= load_data.weight;
         data_ff.vrt <= load_data.vrt;
      end else if (shift) begin
         data_ff.prio <= prev_data.prio;
         data_ff.weight <= prev_data.weight;
         data_ff.vrt <= prev_data.vrt;
      end
   end

   assign data = data_ff;
endmodule

// File: rtl/tsp_divider.sv
// tsp_divider: restoring divider, one quotient bit per cycle
// depends on tsp_pkg
module tsp_divider (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [48:0]                dividend,
   input  logic [tsp_pkg::WeightW-1:0] divisor,
   output logic                       done,
   output logic [48:0]                quotient
);
   logic [48:0] quot_ff, quot_in;
   logic [tsp_pkg::WeightW-1:0] rem_ff, rem_in;
   logic [tsp_pkg::WeightW-1:0] div_ff, div_in;
   logic [5:0] cnt_ff, cnt_in;
   logic run_ff, run_in;
   logic [tsp_pkg::WeightW:0] trial;

   always_comb begin
      quot_in = quot_ff;
      rem_in = rem_ff;
      div_in = div_ff;
      cnt_in = cnt_ff;
      run_in = run_ff;
      trial = '0;
      done = 1'b0;
      if (start) begin
         quot_in = dividend;
         rem_in = '0;
         div_in = (divisor == '0) ? tsp_pkg::WeightW'(1) : divisor;
         cnt_in = 6'd49;
         run_in = 1'b1;
      end else if (run_ff) begin
         trial = {rem_ff, quot_ff[48]};
         if (trial >= {1'b0, div_ff}) begin
            rem_in = trial[tsp_pkg::WeightW-1:0] - div_ff;
            quot_in = {quot_ff[47:0], 1'b1};
         end else begin
            rem_in = trial[tsp_pkg::WeightW-1:0];
            quot_in = {quot_ff[47:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            run_in = 1'b0;
            done = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         run_ff <= run_in;
         cnt_ff <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign quotient = quot_in;
endmodule

// File: rtl/task_scheduler_picker_unit.sv
// task_scheduler_picker_unit: task table as a rotating ring of slot cells
// depends on tsp_pkg, tsp_cell, tsp_divider
// add and remove: one full turn of the ring, with the edit made at its head
// pick: one ring turn; fair pick first turns the current slot to the head, runs the
// weight division when it is valid, then makes a ring turn
// one item at a time; busy is high from acceptance until the result strobe
// synchronous reset clears all valid marks and current slot, sets policy to round robin and nice0 load to 1024
module task_scheduler_picker_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_mode,
   input  logic [5:0]  req_slot,
   input  logic [7:0]  req_task_prio,
   input  logic [16:0] req_load_weight,
   input  logic [31:0] req_delta_exec,
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [16:0] csr_wdata,
   output logic        rsp_strobe,
   output logic [5:0]  rsp_next_slot,
   output logic        rsp_picked,
   output logic        rsp_empty_error
);
   localparam int N = tsp_pkg::MaxTasks;
   localparam int SW = tsp_pkg::SlotW;

   tsp_pkg::state_type state_ff, state_in;
   tsp_pkg::entry_type cell_q [N];
   tsp_pkg::entry_type head_load;

   logic [1:0]  policy_ff;
   logic [16:0] nice_ff;
   logic [SW-1:0] cur_ff, cur_in;
   logic [1:0]  mode_ff;
   logic [SW-1:0] slot_ff;
   logic [7:0]  prio_ff;
   logic [16:0] wgt_ff;
   logic [31:0] delta_ff;
   logic [SW:0] cnt_ff, cnt_in;
   logic [SW-1:0] pos_ff, pos_in;
   logic        found_ff, found_in;
   logic [SW-1:0] sel_ff, sel_in;
   logic [63:0] best_ff, best_in;
   logic [SW:0] rr_ff, rr_in;
   logic [63:0] inc_ff;
   logic        shift, head_ld;
   logic        strobe_ff, strobe_in;
   logic [SW-1:0] out_slot_ff, out_slot_in;
   logic        out_pick_ff, out_pick_in, out_err_ff, out_err_in;
   logic        div_start, div_done;
   logic [48:0] div_q;
   logic [SW-1:0] rr_offset;
   logic [64:0] sum;

   tsp_pkg::entry_type head;
   assign head = cell_q[0];

   for (genvar i = 0; i < N; i++) begin : g_ring
      tsp_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .shift     (shift),
         .load      (head_ld && (i == N - 1)),
         .load_data (head_load),
         .prev_data (cell_q[(i + 1) % N]),
         .data      (cell_q[i])
      );
   end

   tsp_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({32'd0, 17'd0} | (49'(delta_ff) * 49'(nice_ff))),
      .divisor  (head.weight),
      .done     (div_done),
      .quotient (div_q)
   );

   always_comb begin
      state_in = state_ff;
      cur_in = cur_ff;
      cnt_in = cnt_ff;
      pos_in = pos_ff;
      found_in = found_ff;
      sel_in = sel_ff;
      best_in = best_ff;
      rr_in = rr_ff;
      shift = 1'b0;
      head_ld = 1'b0;
      head_load = head;
      strobe_in = 1'b0;
      out_slot_in = '0;
      out_pick_in = 1'b0;
      out_err_in = 1'b0;
      div_start = 1'b0;
      sum = 65'(head.vrt) + 65'(inc_ff);
      rr_offset = pos_ff - cur_ff;
      case (state_ff)
         tsp_pkg::ST_IDLE: begin
            if (start) begin
               cnt_in = '0;
               found_in = 1'b0;
               best_in = '1;
               rr_in = '1;
               sel_in = '0;
               if (req_mode == tsp_pkg::ModePick && policy_ff == tsp_pkg::PolCfs) begin
                  state_in = tsp_pkg::ST_DIV;
               end else begin
                  state_in = tsp_pkg::ST_SCAN;
               end
            end
         end
         tsp_pkg::ST_DIV: begin
            // rotate until the current slot sits at the head
            if (pos_ff != cur_ff) begin
               shift = 1'b1;
               pos_in = pos_ff + SW'(1);
            end else if (!head.valid) begin
               state_in = tsp_pkg::ST_SCAN;
            end else if (cnt_ff == '0) begin
               div_start = 1'b1;
               cnt_in = SW'(1) + (SW + 1)'(0);
            end else if (div_done) begin
               state_in = tsp_pkg::ST_UPD;
            end
         end
         tsp_pkg::ST_UPD: begin
            head_ld = 1'b1;
            shift = 1'b1;
            head_load.vrt = sum[64] ? '1 : sum[63:0];
            best_in = head_load.vrt;
            pos_in = pos_ff + SW'(1);
            cnt_in = '0;
            state_in = tsp_pkg::ST_SCAN;
         end
         tsp_pkg::ST_SCAN: begin
            if (cnt_ff == (SW + 1)'(N)) begin
               state_in = tsp_pkg::ST_DONE;
            end else begin
               shift = 1'b1;
               pos_in = pos_ff + SW'(1);
               cnt_in = cnt_ff + (SW + 1)'(1);
               if (mode_ff == tsp_pkg::ModeAdd && pos_ff == slot_ff) begin
                  head_ld = 1'b1;
                  head_load.valid = 1'b1;
                  head_load.prio = prio_ff;
                  head_load.weight = wgt_ff;
                  head_load.vrt = '0;
               end else if (mode_ff == tsp_pkg::ModeRemove && pos_ff == slot_ff) begin
                  head_ld = 1'b1;
                  head_load.valid = 1'b0;
               end else if (mode_ff == tsp_pkg::ModePick && head.valid) begin
                  case (policy_ff)
                     tsp_pkg::PolPrio: begin
                        // ties go to the higher slot index
                        if (!found_ff || {56'd0, head.prio} < best_ff ||
                              ({56'd0, head.prio} == best_ff && pos_ff > sel_ff)) begin
                           best_in = {56'd0, head.prio};
                           sel_in = pos_ff;
                           found_in = 1'b1;
                        end
                     end
                     tsp_pkg::PolCfs: begin
                        if (head.vrt < best_ff ||
                              (head.vrt == best_ff && (!found_ff || pos_ff > sel_ff))) begin
                           best_in = head.vrt;
                           sel_in = pos_ff;
                           found_in = 1'b1;
                        end
                     end
                     default: begin
                        // distance after current, current itself counts as last
                        if ({1'b0, rr_offset - SW'(1)} < rr_ff) begin
                           rr_in = {1'b0, rr_offset - SW'(1)};
                           sel_in = pos_ff;
                           found_in = 1'b1;
                        end
                     end
                  endcase
               end
            end
         end
         tsp_pkg::ST_DONE: begin
            strobe_in = 1'b1;
            state_in = tsp_pkg::ST_IDLE;
            if (mode_ff == tsp_pkg::ModePick) begin
               if (found_ff) begin
                  cur_in = sel_ff;
                  out_slot_in = sel_ff;
                  out_pick_in = 1'b1;
               end else begin
                  out_err_in = 1'b1;
               end
            end
         end
         default: state_in = tsp_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tsp_pkg::ST_IDLE;
         policy_ff <= tsp_pkg::PolRr;
         nice_ff <= 17'd1024;
         cur_ff <= '0;
         pos_ff <= '0;
         cnt_ff <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cur_ff <= cur_in;
         pos_ff <= pos_in;
         cnt_ff <= cnt_in;
         strobe_ff <= strobe_in;
         if (csr_we) begin
            if (csr_index == tsp_pkg::csr_policy_idx) begin
               policy_ff <= csr_wdata[1:0];
            end else begin
               nice_ff <= csr_wdata;
            end
         end
      end
      found_ff <= found_in;
      sel_ff <= sel_in;
      best_ff <= best_in;
      rr_ff <= rr_in;
      out_slot_ff <= out_slot_in;
      out_pick_ff <= out_pick_in;
      out_err_ff <= out_err_in;
      if (div_done) begin
         inc_ff <= {15'd0, div_q};
      end
      if (state_ff == tsp_pkg::ST_IDLE && start) begin
         mode_ff <= req_mode;
         slot_ff <= req_slot;
         prio_ff <= req_task_prio;
         wgt_ff <= req_load_weight;
         delta_ff <= req_delta_exec;
      end
   end

   assign busy = (state_ff != tsp_pkg::ST_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_next_slot = out_slot_ff;
   assign rsp_picked = out_pick_ff;
   assign rsp_empty_error = out_err_ff;
endmodule

// File: dv/tb_task_scheduler_picker_unit.sv
// tb_task_scheduler_picker_unit: self-checking testbench for the task scheduler picker
// depends on tsp_pkg and task_scheduler_picker_unit; predicts each result in a local
// copy of the task table and checks every strobed result against it
module tb_task_scheduler_picker_unit;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [5:0] next_slot;
      logic       picked;
      logic       empty_error;
   } pick_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_mode = '0;
   logic [5:0]  req_slot = '0;
   logic [7:0]  req_task_prio = '0;
   logic [16:0] req_load_weight = '0;
   logic [31:0] req_delta_exec = '0;
   logic        csr_we = 1'b0;
   logic [0:0]  csr_index = '0;
   logic [16:0] csr_wdata = '0;
   logic        rsp_strobe;
   logic [5:0]  rsp_next_slot;
   logic        rsp_picked;
   logic        rsp_empty_error;

   task_scheduler_picker_unit dut (.*);

   bit                          mdl_valid [tsp_pkg::MaxTasks];
   logic [tsp_pkg::PrioW-1:0]   mdl_prio [tsp_pkg::MaxTasks];
   logic [tsp_pkg::WeightW-1:0] mdl_weight [tsp_pkg::MaxTasks];
   logic [tsp_pkg::VrtW-1:0]    mdl_vrt [tsp_pkg::MaxTasks];
   logic [tsp_pkg::SlotW-1:0]   mdl_current;
   logic [1:0]                  mdl_policy;
   logic [16:0]                 mdl_nice0;

   pick_result_type expected_results [$];
   int mismatch_count = 0;

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("FAIL");
      $finish;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      mismatch_count++;
   endtask

   function automatic pick_result_type predict_item(input logic [1:0] mode,
         input logic [5:0] slot, input logic [7:0] prio, input logic [16:0] weight,
         input logic [31:0] delta);
      pick_result_type r;
      bit found;
      logic [5:0] sel;
      logic [7:0] best;
      logic [63:0] limit, inc, v;
      logic [63:0] w;
      int idx;
      r = '0;
      found = 0;
      sel = '0;
      best = '0;
      if (mode == tsp_pkg::ModeAdd) begin
         mdl_valid[slot] = 1;
         mdl_prio[slot] = prio;
         mdl_weight[slot] = weight;
         mdl_vrt[slot] = '0;
      end else if (mode == tsp_pkg::ModeRemove) begin
         mdl_valid[slot] = 0;
      end else if (mode == tsp_pkg::ModePick) begin
         if (mdl_policy == tsp_pkg::PolPrio) begin
            for (int i = 0; i < tsp_pkg::MaxTasks; i++)
               if (mdl_valid[i] && (!found || mdl_prio[i] <= best)) begin
                  best = mdl_prio[i];
                  sel = 6'(i);
                  found = 1;
               end
         end else if (mdl_policy == tsp_pkg::PolCfs) begin
            limit = '1;
            if (mdl_valid[mdl_current]) begin
               w = (mdl_weight[mdl_current] == 0) ? 64'd1 : 64'(mdl_weight[mdl_current]);
               inc = (64'(delta) * 64'(mdl_nice0)) / w;
               v = mdl_vrt[mdl_current];
               v = ((64'hFFFF_FFFF_FFFF_FFFF - v) < inc) ? 64'hFFFF_FFFF_FFFF_FFFF : v + inc;
               mdl_vrt[mdl_current] = v;
               limit = v;
            end
            for (int i = 0; i < tsp_pkg::MaxTasks; i++)
               if (mdl_valid[i] && mdl_vrt[i] <= limit) begin
                  limit = mdl_vrt[i];
                  sel = 6'(i);
                  found = 1;
               end
         end else begin
            for (int k = 1; k <= tsp_pkg::MaxTasks && !found; k++) begin
               idx = (int'(mdl_current) + k) % tsp_pkg::MaxTasks;
               if (mdl_valid[idx]) begin
                  sel = 6'(idx);
                  found = 1;
               end
            end
         end
         if (found) begin
            mdl_current = sel;
            r.next_slot = sel;
            r.picked = 1;
         end else begin
            r.empty_error = 1;
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin
      pick_result_type want;
      if (!reset && rsp_strobe) begin
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected result", 1, 0);
         end else begin
            want = expected_results.pop_front();
            if (rsp_next_slot !== want.next_slot)
               report_mismatch("next_slot", rsp_next_slot, want.next_slot);
            if (rsp_picked !== want.picked)
               report_mismatch("picked", rsp_picked, want.picked);
            if (rsp_empty_error !== want.empty_error)
               report_mismatch("empty_error", rsp_empty_error, want.empty_error);
         end
      end
   end

   task automatic send_item(input logic [1:0] mode, input logic [5:0] slot,
         input logic [7:0] prio, input logic [16:0] weight, input logic [31:0] delta);
      int gap;
      gap = $urandom_range(0, 9);
      if ($urandom_range(0, 3) == 0) gap = 0;
      repeat (gap) @(posedge clock);
      while (busy) @(posedge clock);
      start <= 1'b1;
      req_mode <= mode;
      req_slot <= slot;
      req_task_prio <= prio;
      req_load_weight <= weight;
      req_delta_exec <= delta;
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_results.push_back(predict_item(mode, slot, prio, weight, delta));
      start <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_idle();
      while (expected_results.size() != 0) @(posedge clock);
      repeat (130) @(posedge clock);
   endtask

   task automatic write_csr(input logic [0:0] index, input logic [16:0] value);
      wait_idle();
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (index == tsp_pkg::csr_policy_idx) mdl_policy = value[1:0];
      else mdl_nice0 = value;
   endtask

   task automatic send_random_item(input int pick_share);
      logic [1:0] mode;
      int r;
      r = $urandom_range(0, 99);
      if (r < pick_share) mode = tsp_pkg::ModePick;
      else if (r < pick_share + (100 - pick_share) * 3 / 5) mode = tsp_pkg::ModeAdd;
      else if (r < 98) mode = tsp_pkg::ModeRemove;
      else mode = 2'd3;
      send_item(mode, 6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)),
         ($urandom_range(0, 7) == 0) ? 17'h1FFFF : 17'($urandom_range(0, 131071)),
         ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFFF : $urandom);
   endtask

   task automatic test_directed();
      send_item(tsp_pkg::ModePick, 6'd0, 8'd0, 17'd1, 32'd0);
      send_item(tsp_pkg::ModeRemove, 6'd5, 8'd0, 17'd1, 32'd0);
      send_item(tsp_pkg::ModeAdd, 6'd0, 8'd0, 17'd1, 32'd0);
      send_item(tsp_pkg::ModeAdd, 6'd63, 8'hFF, 17'h1FFFF, 32'hFFFF_FFFF);
      send_item(tsp_pkg::ModeAdd, 6'd10, 8'd139, 17'h1FFFF, 32'd0);
      send_item(tsp_pkg::ModeAdd, 6'd20, 8'd139, 17'd1, 32'd0);
      send_item(2'd3, 6'd42, 8'hAA, 17'h15555, 32'h5555_5555);
      send_item(tsp_pkg::ModePick, 6'd0, 8'd0, 17'd1, 32'd0);
      send_item(tsp_pkg::ModePick, 6'd0, 8'd0, 17'd1, 32'd0);
      send_item(tsp_pkg::ModeRemove, 6'd10, 8'd0, 17'd1, 32'd0);
      send_item(tsp_pkg::ModePick, 6'd0, 8'd0, 17'd1, 32'd0);
      send_item(tsp_pkg::ModeAdd, 6'd0, 8'd0, 17'd1, 32'd0);
      write_csr(tsp_pkg::csr_policy_idx, 17'(tsp_pkg::PolPrio));
      send_item(tsp_pkg::ModePick, 6'd0, 8'd0, 17'd1, 32'd0);
      send_item(tsp_pkg::ModeAdd, 6'd10, 8'd139, 17'd0, 32'd0);
      send_item(tsp_pkg::ModePick, 6'd0, 8'd0, 17'd1, 32'd0);
      write_csr(tsp_pkg::csr_policy_idx, 17'(tsp_pkg::PolCfs));
      write_csr(tsp_pkg::csr_nice_idx, 17'h1FFFF);
      send_item(tsp_pkg::ModePick, 6'd0, 8'd0, 17'd1, 32'hFFFF_FFFF);
      send_item(tsp_pkg::ModePick, 6'd0, 8'd0, 17'd1, 32'hFFFF_FFFF);
      send_item(tsp_pkg::ModeAdd, 6'd33, 8'd0, 17'd0, 32'd0);
      send_item(tsp_pkg::ModePick, 6'd0, 8'd0, 17'd1, 32'h1234);
      write_csr(tsp_pkg::csr_nice_idx, 17'd0);
      send_item(tsp_pkg::ModePick, 6'd0, 8'd0, 17'd1, 32'hFFFF_FFFF);
      write_csr(tsp_pkg::csr_policy_idx, 17'd3);
      send_item(tsp_pkg::ModePick, 6'd0, 8'd0, 17'd1, 32'd0);
      for (int i = 0; i < 4; i++)
         send_item(tsp_pkg::ModeRemove, 6'(i * 21), 8'd0, 17'd1, 32'd0);
   endtask

   task automatic test_policy_phase(input logic [1:0] policy, input logic [16:0] nice0,
         input int count);
      write_csr(tsp_pkg::csr_policy_idx, 17'(policy));
      write_csr(tsp_pkg::csr_nice_idx, nice0);
      for (int i = 0; i < count; i++) send_random_item(40);
   endtask

   task automatic test_saturation();
      write_csr(tsp_pkg::csr_policy_idx, 17'(tsp_pkg::PolCfs));
      write_csr(tsp_pkg::csr_nice_idx, 17'h1FFFF);
      for (int i = 0; i < 64; i++) send_item(tsp_pkg::ModeRemove, 6'(i), 8'd0, 17'd1, 32'd0);
      send_item(tsp_pkg::ModeAdd, 6'd7, 8'd0, 17'd1, 32'd0);
      send_item(tsp_pkg::ModeAdd, 6'd9, 8'd0, 17'd1, 32'd0);
      for (int i = 0; i < 60; i++)
         send_item(tsp_pkg::ModePick, 6'd0, 8'd0, 17'd1, 32'hFFFF_FFFF);
   endtask

   initial begin
      for (int i = 0; i < tsp_pkg::MaxTasks; i++) begin
         mdl_valid[i] = 0;
         mdl_prio[i] = '0;
         mdl_weight[i] = '0;
         mdl_vrt[i] = '0;
      end
      mdl_current = '0;
      mdl_policy = tsp_pkg::PolRr;
      mdl_nice0 = 17'd1024;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_policy_phase(tsp_pkg::PolRr, 17'd1024, 300);
      test_policy_phase(tsp_pkg::PolPrio, 17'd1, 300);
      test_policy_phase(tsp_pkg::PolCfs, 17'd1024, 350);
      test_policy_phase(tsp_pkg::PolCfs, 17'h1FFFF, 250);
      test_policy_phase(tsp_pkg::PolCfs, 17'd1, 150);
      test_policy_phase(2'd3, 17'd77, 150);
      test_saturation();
      wait_idle();
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule
